// ----- hw/rtl/cursor_overlay_compositor_core_defines.svh -----
// Assertion macros used by the compositor core.
`ifndef CURSOR_OVERLAY_COMPOSITOR_CORE_DEFINES_SVH
`define CURSOR_OVERLAY_COMPOSITOR_CORE_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define COC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked out of reset.
`define COC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/coc_pkg.sv -----
`default_nettype none

package coc_pkg;

    // Item opcodes
    localparam logic OpLoad  = 1'b0;
    localparam logic OpPixel = 1'b1;

    // Shape types
    typedef logic [1:0] t_shape_type;
    localparam t_shape_type ShapeColor  = 2'd0;
    localparam t_shape_type ShapeMono   = 2'd1;
    localparam t_shape_type ShapeMasked = 2'd2;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CfgCursorX      = 3'd0,
        CfgCursorY      = 3'd1,
        CfgCursorWidth  = 3'd2,
        CfgCursorHeight = 3'd3,
        CfgShapeType    = 3'd4,
        CfgVisible      = 3'd5,
        CfgFrameWidth   = 3'd6,
        CfgFrameHeight  = 3'd7
    } t_cfg_idx;

    localparam int CfgDataW = 13;

    // Reset frame size
    localparam logic [12:0] FrameWidthRst  = 13'd1920;
    localparam logic [12:0] FrameHeightRst = 13'd1080;

    // Pixel masks
    localparam logic [31:0] MaskAll   = 32'hFFFF_FFFF;
    localparam logic [31:0] MaskAlpha = 32'hFF00_0000;
    localparam logic [31:0] MaskRgb   = 32'h00FF_FFFF;
    localparam logic [31:0] MaskNone  = 32'h0000_0000;

    // Channel payloads
    typedef struct packed {
        logic        opcode;
        logic [11:0] shape_addr;
        logic [31:0] shape_word;
        logic [11:0] pixel_x;
        logic [11:0] pixel_y;
        logic [31:0] screen_pixel;
    } t_in_item;

    typedef struct packed {
        logic [31:0] out_pixel;
        logic        cursor_hit;
    } t_out_item;

endpackage

`default_nettype wire

// ----- hw/rtl/coc_in_if.sv -----
`default_nettype none

interface coc_in_if
    import coc_pkg::*;
();
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/coc_out_if.sv -----
`default_nettype none

interface coc_out_if
    import coc_pkg::*;
();
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/cursor_overlay_compositor_core.sv -----
// Channel   Dir  Transaction                               Result
// i_in      in   load shape word, or composite one pixel    pixel: one on o_out
// o_out     out  composited pixel and cursor hit flag       -
// i_cfg_*   in   register write, index and data              none
//
// One transaction per cycle on i_in, loads and pixels alike, while o_out is not stalled.
// A taken pixel passes the read stage (shape store read), then the blend into the output register.
// The shape store is one 1W/1R RAM with a registered read port.
// A stall on o_out holds the read stage and then i_in; no bubble on release.
// Synchronous reset clears control and sets configuration to its reset values; the shape store is
// not cleared and needs loading before the cursor is drawn.
`default_nettype none
`include "cursor_overlay_compositor_core_defines.svh"

module cursor_overlay_compositor_core
    import coc_pkg::*;
#(
    parameter int CURSOR_DIM = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_cfg_we,
    input  wire logic [2:0]          i_cfg_idx,
    input  wire logic [CfgDataW-1:0] i_cfg_data,
    coc_in_if.sink                   i_in,
    coc_out_if.source                o_out
);
    localparam int Depth = CURSOR_DIM * CURSOR_DIM;
    localparam int AddrW = $clog2(Depth);
    localparam int ColW  = $clog2(CURSOR_DIM);
    localparam int WideW = (AddrW + 1 > 12) ? AddrW + 1 : 12;
    localparam logic [12:0]      Dim13     = 13'(CURSOR_DIM);
    localparam logic [WideW-1:0] DepthWide = WideW'(Depth);

    // Size after saturation and clipping to the frame
    function automatic logic [12:0] clip_extent(input logic [12:0] size,
                                                input logic [12:0] start,
                                                input logic [12:0] frame);
        logic [12:0] sat;
        logic [12:0] room;
        begin
            sat  = (size > Dim13) ? Dim13 : size;
            room = frame - start;
            if (start >= frame) begin
                clip_extent = 13'd0;
            end else begin
                clip_extent = (sat < room) ? sat : room;
            end
        end
    endfunction

    // Configuration registers
    logic [11:0] r_cursor_x;
    logic [11:0] r_cursor_y;
    logic [6:0]  r_cursor_width;
    logic [7:0]  r_cursor_height;
    t_shape_type r_shape_type;
    logic        r_cursor_visible;
    logic [12:0] r_frame_width;
    logic [12:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cursor_x       <= '0;
            r_cursor_y       <= '0;
            r_cursor_width   <= '0;
            r_cursor_height  <= '0;
            r_shape_type     <= ShapeColor;
            r_cursor_visible <= 1'b0;
            r_frame_width    <= FrameWidthRst;
            r_frame_height   <= FrameHeightRst;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CfgCursorX:      r_cursor_x       <= i_cfg_data[11:0];
                CfgCursorY:      r_cursor_y       <= i_cfg_data[11:0];
                CfgCursorWidth:  r_cursor_width   <= i_cfg_data[6:0];
                CfgCursorHeight: r_cursor_height  <= i_cfg_data[7:0];
                CfgShapeType:    r_shape_type     <= i_cfg_data[1:0];
                CfgVisible:      r_cursor_visible <= i_cfg_data[0];
                CfgFrameWidth:   r_frame_width    <= i_cfg_data[12:0];
                CfgFrameHeight:  r_frame_height   <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // Pipeline control
    logic r_s1_valid;
    logic r_out_valid;
    logic s1_adv;
    logic in_acc;
    logic pix_acc;
    logic load_acc;

    assign s1_adv     = !r_out_valid || o_out.ready;
    assign i_in.ready = !r_s1_valid || s1_adv;
    assign in_acc     = i_in.valid && i_in.ready;
    assign pix_acc    = in_acc && (i_in.data.opcode == OpPixel);
    assign load_acc   = in_acc && (i_in.data.opcode == OpLoad);

    // Hit test and shape address
    logic [12:0]      h_eff;
    logic [12:0]      w_clip;
    logic [12:0]      h_clip;
    logic [12:0]      dx;
    logic [12:0]      dy;
    logic             hit;
    logic [AddrW-1:0] rd_addr;
    logic [WideW-1:0] wr_addr_wide;
    logic             wr_ok;

    always_comb begin
        h_eff  = (r_shape_type == ShapeMono) ? {6'd0, r_cursor_height[7:1]}
                                             : {5'd0, r_cursor_height};
        w_clip = clip_extent({6'd0, r_cursor_width}, {1'b0, r_cursor_x}, r_frame_width);
        h_clip = clip_extent(h_eff, {1'b0, r_cursor_y}, r_frame_height);
        dx     = {1'b0, i_in.data.pixel_x} - {1'b0, r_cursor_x};
        dy     = {1'b0, i_in.data.pixel_y} - {1'b0, r_cursor_y};
        hit    = r_cursor_visible
              && (i_in.data.pixel_x >= r_cursor_x) && (dx < w_clip)
              && (i_in.data.pixel_y >= r_cursor_y) && (dy < h_clip);
        rd_addr = AddrW'(dy[ColW-1:0]) * AddrW'(CURSOR_DIM) + AddrW'(dx[ColW-1:0]);
        wr_addr_wide = WideW'(i_in.data.shape_addr);
        wr_ok        = wr_addr_wide < DepthWide;
    end

    // Shape store
    logic [31:0] shape_rd;

    coc_ram #(
        .WIDTH (32),
        .DEPTH (Depth)
    ) u_shape_ram (
        .i_clk   (i_clk),
        .i_we    (load_acc && wr_ok),
        .i_waddr (wr_addr_wide[AddrW-1:0]),
        .i_wdata (i_in.data.shape_word),
        .i_re    (pix_acc),
        .i_raddr (rd_addr),
        .o_rdata (shape_rd)
    );

    // Read stage
    logic        n_s1_valid;
    logic [31:0] r_s1_pix;
    logic        r_s1_hit;

    assign n_s1_valid = pix_acc || (r_s1_valid && !s1_adv);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_s1_pix <= i_in.data.screen_pixel;
            r_s1_hit <= hit;
        end
    end

    // Blend
    logic [31:0] blend_pix;

    always_comb begin
        blend_pix = r_s1_pix;
        if (r_s1_hit) begin
            case (r_shape_type)
                ShapeColor:  blend_pix = (shape_rd != MaskNone) ? shape_rd : r_s1_pix;
                ShapeMono:   blend_pix = (r_s1_pix & (shape_rd[0] ? MaskAll : MaskAlpha))
                                       ^ (shape_rd[1] ? MaskRgb : MaskNone);
                ShapeMasked: blend_pix = ((shape_rd & MaskAlpha) != MaskNone)
                                       ? ((r_s1_pix ^ shape_rd) | MaskAlpha)
                                       : (shape_rd | MaskAlpha);
                default:     blend_pix = r_s1_pix;
            endcase
        end
    end

    // Output register
    logic        n_out_valid;
    logic [31:0] r_out_pixel;
    logic        r_out_hit;

    assign n_out_valid = (r_s1_valid && s1_adv) || (r_out_valid && !o_out.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_s1_valid && s1_adv) begin
            r_out_pixel <= blend_pix;
            r_out_hit   <= r_s1_hit;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.data.out_pixel  = r_out_pixel;
    assign o_out.data.cursor_hit = r_out_hit;

    // Checks
    `COC_ASSERT_NEXT(a_pix_enters_s1, i_clk, i_rst_n, pix_acc, r_s1_valid, "pixel lost before read stage")
    `COC_ASSERT_NEXT(a_s1_holds, i_clk, i_rst_n, r_s1_valid && !s1_adv, r_s1_valid && $stable(r_s1_pix) && $stable(r_s1_hit), "read stage changed while stalled")
    `COC_ASSERT_NEXT(a_miss_passes, i_clk, i_rst_n, r_s1_valid && s1_adv && !r_s1_hit, r_out_valid && !r_out_hit && (r_out_pixel == $past(r_s1_pix)), "missed pixel altered")
    `COC_ASSERT_SAME(a_hit_visible, i_clk, i_rst_n, r_out_valid && r_out_hit, r_cursor_visible, "hit while cursor hidden")
endmodule

`default_nettype wire

// ----- hw/rtl/coc_ram.sv -----
`default_nettype none

module coc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port, one registered read port; read data holds without a read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

`default_nettype wire
